// ===== rtl/icpl_pkg.sv =====
// Shared types and constants for the interval cut piece length block.
package icpl_pkg;

    localparam int MAX_CUTS_DEF  = 1024;
    localparam int POS_WIDTH_DEF = 32;
    localparam int LEN_W         = 32;
    localparam int IN_POS_W      = 32;
    localparam int CFG_W         = 32;
    localparam int STS_W         = 2;

    localparam logic CMD_CUT   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_code_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_mid;
        logic upd_search;
        logic rd_k;
        logic get_succ;
        logic rd_km1;
        logic get_pred;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic insert;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic k_lt_count;
        logic k_gt_zero;
        logic is_query;
        logic rejected;
        logic cut_ok_now;
        logic shift_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/interval_cut_piece_length_top.sv =====
// Top level of the interval cut piece length block.
//
// The block keeps a sorted set of cut positions on a segment running from 0
// to total_length and answers two kinds of items on the input channel.
// With cmd low an item inserts position as a cut; with cmd high it asks for
// the length of the piece holding position. Every input transfer yields one
// output transfer carrying piece_length and status (0 ok, 1 duplicate cut,
// 2 store full, 3 position out of range). Cuts always report a length of 0.
// The cfg channel writes total_length; it is always ready, and it should be
// written only while no item is in flight.
// One item is handled at a time. A search takes at most clog2(MAX_CUTS + 1)
// binary search steps, each a read and then a compare, over the single read
// port of the cut memory. A cut moves every stored cut at or above its slot
// up one slot to make room for it. A finished result waits in the output
// register while the receiver stalls. The next item is still taken and worked
// on, but it holds in its final step until the waiting result transfers.
// Reset empties the set and sets total_length to all ones; the memory needs
// no clearing pass since only filled slots are read.
module interval_cut_piece_length_top import icpl_pkg::*; #(
    parameter int MAX_CUTS  = MAX_CUTS_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [IN_POS_W-1:0] position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEN_W-1:0]    piece_length,
    output logic [STS_W-1:0]    status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    ctrl_cmd_t  ctl;
    dp_status_t flags;

    // The length register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    icpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .flags    (flags),
        .ctl      (ctl)
    );

    icpl_datapath #(
        .MAX_CUTS  (MAX_CUTS),
        .POS_WIDTH (POS_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .flags        (flags),
        .in_cmd       (cmd),
        .position     (position),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .piece_length (piece_length),
        .status       (status)
    );

endmodule

// ===== rtl/icpl_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module icpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                            clk,
    input  logic                                            wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]                                wr_data,
    input  logic                                            rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                                rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/icpl_datapath.sv =====
// Datapath: cut memory, search bounds, neighbor registers and the result register.
module icpl_datapath import icpl_pkg::*; #(
    parameter int MAX_CUTS  = MAX_CUTS_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           ctl,
    output dp_status_t          flags,
    input  logic                in_cmd,
    input  logic [IN_POS_W-1:0] position,
    input  logic                cfg_valid,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [LEN_W-1:0]    piece_length,
    output logic [STS_W-1:0]    status
);

    localparam int CNT_W  = $clog2(MAX_CUTS + 1);
    localparam int ADDR_W = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;

    logic [POS_WIDTH-1:0] total_reg;
    logic [POS_WIDTH-1:0] pos_reg;
    logic                 is_query_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     hi_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ADDR_W-1:0]    j_reg;
    logic [POS_WIDTH-1:0] succ_reg;
    logic [POS_WIDTH-1:0] pred_reg;
    status_code_t         sts_reg;
    logic                 out_valid_reg;
    logic [LEN_W-1:0]     piece_length_reg;
    status_code_t         status_reg;

    logic [POS_WIDTH-1:0] pos_in;
    logic                 in_range_in;
    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     cnt_m1;
    logic [ADDR_W-1:0]    k_addr;
    logic                 hit_now;
    logic                 full;
    logic [POS_WIDTH-1:0] piece_diff;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [POS_WIDTH-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [POS_WIDTH-1:0] ram_rd_data;

    assign pos_in      = POS_WIDTH'(position);
    assign in_range_in = (pos_in != '0) && (pos_in < total_reg);
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[CNT_W:1];
    assign cnt_m1      = cnt_reg - 1'b1;
    assign k_addr      = lo_reg[ADDR_W-1:0];
    assign full        = (cnt_reg == CNT_W'(MAX_CUTS));
    assign hit_now     = (lo_reg < cnt_reg) && (ram_rd_data == pos_reg);
    assign piece_diff  = succ_reg - pred_reg;

    always_comb
    begin
        ram_rd_en   = ctl.rd_mid | ctl.rd_k | ctl.rd_km1 | ctl.shift_rd;
        ram_rd_addr = j_reg;
        if (ctl.rd_mid)
        begin
            ram_rd_addr = mid[ADDR_W-1:0];
        end
        else if (ctl.rd_k)
        begin
            ram_rd_addr = k_addr;
        end
        else if (ctl.rd_km1)
        begin
            ram_rd_addr = k_addr - 1'b1;
        end

        ram_wr_en   = ctl.shift_wr | ctl.insert;
        ram_wr_addr = ctl.insert ? k_addr : (j_reg + 1'b1);
        ram_wr_data = ctl.insert ? pos_reg : ram_rd_data;
    end

    icpl_ram #(
        .WIDTH (POS_WIDTH),
        .DEPTH (MAX_CUTS)
    ) u_cut_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= POS_WIDTH'(32'hFFFF_FFFF);
            cnt_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                total_reg <= POS_WIDTH'(cfg_data);
            end
            if (ctl.load)
            begin
                lo_reg <= '0;
                hi_reg <= cnt_reg;
            end
            else if (ctl.upd_search)
            begin
                if (ram_rd_data < pos_reg)
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (ctl.insert)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pos_reg      <= pos_in;
            is_query_reg <= (in_cmd == CMD_QUERY);
            pred_reg     <= '0;
            sts_reg      <= in_range_in ? ST_OK : ST_RANGE;
        end
        if (ctl.get_succ)
        begin
            if (is_query_reg)
            begin
                if ((lo_reg < cnt_reg) && (ram_rd_data < total_reg))
                begin
                    succ_reg <= ram_rd_data;
                end
                else
                begin
                    succ_reg <= total_reg;
                end
            end
            else if (hit_now)
            begin
                sts_reg <= ST_DUP;
            end
            else if (full)
            begin
                sts_reg <= ST_FULL;
            end
        end
        if (ctl.get_pred)
        begin
            pred_reg <= ram_rd_data;
        end
        if (ctl.shift_init)
        begin
            j_reg <= cnt_m1[ADDR_W-1:0];
        end
        else if (ctl.shift_wr)
        begin
            j_reg <= j_reg - 1'b1;
        end
        if (ctl.emit)
        begin
            status_reg <= sts_reg;
            if (is_query_reg && (sts_reg == ST_OK))
            begin
                piece_length_reg <= LEN_W'(piece_diff);
            end
            else
            begin
                piece_length_reg <= '0;
            end
        end
    end

    assign flags.search_done = (lo_reg >= hi_reg);
    assign flags.k_lt_count  = (lo_reg < cnt_reg);
    assign flags.k_gt_zero   = (lo_reg != '0);
    assign flags.is_query    = is_query_reg;
    assign flags.rejected    = (sts_reg != ST_OK);
    assign flags.cut_ok_now  = !hit_now && !full;
    assign flags.shift_last  = (j_reg == k_addr);
    assign flags.out_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign piece_length = piece_length_reg;
    assign status       = status_reg;

    // The stored count grows by exactly one on each insertion.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("cut count did not step on insert");

    // An insertion only happens while the store has room.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |-> (cnt_reg < CNT_W'(MAX_CUTS)))
        else $error("insert into a full store");

    // The search window stays ordered and inside the stored cuts.
    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.upd_search |=> ((lo_reg <= hi_reg) && (hi_reg <= cnt_reg)))
        else $error("search bounds out of order");

    // A new result is only loaded when the previous one has gone.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

// ===== rtl/icpl_ctrl.sv =====
// Controller state machine that sequences search, neighbor reads and insertion.
module icpl_ctrl import icpl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t flags,
    output ctrl_cmd_t  ctl
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SRCH     = 11'b000_0000_0010,
        S_CMP      = 11'b000_0000_0100,
        S_RD_SUCC  = 11'b000_0000_1000,
        S_GET_SUCC = 11'b000_0001_0000,
        S_RD_PRED  = 11'b000_0010_0000,
        S_GET_PRED = 11'b000_0100_0000,
        S_SH_RD    = 11'b000_1000_0000,
        S_SH_WR    = 11'b001_0000_0000,
        S_INSERT   = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (flags.rejected)
                begin
                    state_next = S_FINISH;
                end
                else if (flags.search_done)
                begin
                    state_next = S_RD_SUCC;
                end
                else
                begin
                    ctl.rd_mid = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.upd_search = 1'b1;
                state_next     = S_SRCH;
            end
            S_RD_SUCC:
            begin
                ctl.rd_k   = 1'b1;
                state_next = S_GET_SUCC;
            end
            S_GET_SUCC:
            begin
                ctl.get_succ = 1'b1;
                if (flags.is_query)
                begin
                    state_next = flags.k_gt_zero ? S_RD_PRED : S_FINISH;
                end
                else if (!flags.cut_ok_now)
                begin
                    state_next = S_FINISH;
                end
                else if (flags.k_lt_count)
                begin
                    ctl.shift_init = 1'b1;
                    state_next     = S_SH_RD;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_RD_PRED:
            begin
                ctl.rd_km1 = 1'b1;
                state_next = S_GET_PRED;
            end
            S_GET_PRED:
            begin
                ctl.get_pred = 1'b1;
                state_next   = S_FINISH;
            end
            S_SH_RD:
            begin
                ctl.shift_rd = 1'b1;
                state_next   = S_SH_WR;
            end
            S_SH_WR:
            begin
                ctl.shift_wr = 1'b1;
                state_next   = flags.shift_last ? S_INSERT : S_SH_RD;
            end
            S_INSERT:
            begin
                ctl.insert = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (flags.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A comparison step always follows a memory read issued by the search.
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $past(ctl.rd_mid))
        else $error("search compare without a read");

    // The shift write always follows its own read.
    a_shift_pair: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_rd |=> ctl.shift_wr)
        else $error("shift read not followed by its write");

    // Exactly one state bit is set at any time.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

endmodule

// ===== tb/interval_cut_piece_length_top_tb.sv =====
// Self-checking testbench for the interval cut piece length block.
`timescale 1ns / 100ps

module interval_cut_piece_length_top_tb import icpl_pkg::*; ();

    // The store depth and position width match the defaults of the block.
    localparam int STORE_DEPTH    = MAX_CUTS_DEF;
    localparam int SOFT_CUT_CAP   = 300;
    localparam int RANDOM_PER_SEG = 150;
    localparam int QUIET_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 64;

    // One expected output transfer.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        status_code_t     sts;
    } piece_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                cmd;
    logic [IN_POS_W-1:0] position;
    logic                out_valid;
    logic                out_ready;
    logic [LEN_W-1:0]    piece_length;
    logic [STS_W-1:0]    status;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;

    // Shadow copy of the block state, kept in step with accepted transfers.
    logic [IN_POS_W-1:0] known_cuts[$];
    logic [CFG_W-1:0]    seg_length;

    piece_result_t expected_pieces[$];
    int            mismatch_count;
    int            quiet_cycles;
    bit            gaps_on;

    interval_cut_piece_length_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .piece_length (piece_length),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Index of the first stored cut at or above p, so the set stays sorted.
    function automatic int first_cut_at_or_above(input logic [IN_POS_W-1:0] p);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = known_cuts.size();
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (known_cuts[mid] < p)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic bit is_known_cut(input logic [IN_POS_W-1:0] p);
        int k;
        k = first_cut_at_or_above(p);
        return (k < known_cuts.size()) && (known_cuts[k] == p);
    endfunction

    // Works out the result of one item and applies any insertion it makes.
    // The range check comes first, then duplicates, then a full store.
    function automatic piece_result_t predict_piece(input logic item_cmd,
                                                    input logic [IN_POS_W-1:0] item_pos);
        piece_result_t       r;
        int                  k;
        logic [CFG_W-1:0]    succ;
        logic [CFG_W-1:0]    pred;
        r.len = '0;
        r.sts = ST_OK;
        k = first_cut_at_or_above(item_pos);
        if (item_pos < 1 || item_pos >= seg_length)
            r.sts = ST_RANGE;
        else if (item_cmd == CMD_CUT)
        begin
            if (k < known_cuts.size() && known_cuts[k] == item_pos)
                r.sts = ST_DUP;
            else if (known_cuts.size() >= STORE_DEPTH)
                r.sts = ST_FULL;
            else
                known_cuts.insert(k, item_pos);
        end
        else
        begin
            // Cuts left beyond a shortened segment are clamped to its end.
            succ = (k < known_cuts.size()) ? known_cuts[k] : seg_length;
            if (succ > seg_length)
                succ = seg_length;
            pred = (k > 0) ? known_cuts[k - 1] : '0;
            r.len = succ - pred;
        end
        return r;
    endfunction

    // Draws a position for one random item. Draws land anywhere, low in the segment,
    // near its ends, or on and beside stored cuts, where the interesting cases live.
    function automatic logic [IN_POS_W-1:0] pick_position(input logic item_cmd);
        int                  sel;
        int                  idx;
        logic [IN_POS_W-1:0] p;
        sel = $urandom_range(0, 9);
        // Once the store is large, cuts mostly revisit stored positions so that
        // each insertion stays cheap and the store does not fill too early.
        if (item_cmd == CMD_CUT && known_cuts.size() >= SOFT_CUT_CAP && sel < 8)
        begin
            idx = $urandom_range(0, known_cuts.size() - 1);
            return known_cuts[idx];
        end
        case (sel)
            0, 1:
                p = $urandom;
            2:
                case ($urandom_range(0, 7))
                    0: p = '0;
                    1: p = 1;
                    2: p = 2;
                    3: p = seg_length - 2;
                    4: p = seg_length - 1;
                    5: p = seg_length;
                    6: p = seg_length + 1;
                    default: p = '1;
                endcase
            3, 4, 5:
                if (known_cuts.size() == 0)
                    p = $urandom_range(1, 100);
                else
                begin
                    idx = $urandom_range(0, known_cuts.size() - 1);
                    p = known_cuts[idx] + $urandom_range(0, 2) - 1;
                end
            default:
                if (seg_length <= 5000)
                    p = $urandom_range(0, seg_length + 1);
                else
                    p = $urandom_range(0, 5000);
        endcase
        return p;
    endfunction

    // Sends one item and records its expected result once the transfer happens.
    // It is entered and left at a falling edge, and it leaves valid high so that
    // back-to-back items need no second assignment in one time step.
    task automatic send_item(input logic item_cmd, input logic [IN_POS_W-1:0] item_pos);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        cmd      <= item_cmd;
        position <= item_pos;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_pieces.push_back(predict_piece(item_cmd, item_pos));
        @(negedge clk);
    endtask

    // Holds off the sender until every expected result has transferred.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_pieces.size() != 0);
    endtask

    // Writes total_length; only called with the block idle.
    task automatic write_total_length(input logic [CFG_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        seg_length = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what,
                     exp_val, act_val);
    endtask

    // Positions 0 and all ones, and the two ends of the valid range, on an
    // empty store at the reset length.
    task automatic test_range_limits();
        send_item(CMD_QUERY, '0);
        send_item(CMD_QUERY, '1);
        send_item(CMD_CUT, '0);
        send_item(CMD_CUT, '1);
        send_item(CMD_QUERY, 1);
        send_item(CMD_QUERY, 32'hFFFF_FFFE);
    endtask

    // Cuts at both ends and in the middle, then queries on, between and
    // next to them.
    task automatic test_cut_and_query();
        send_item(CMD_CUT, 1);
        send_item(CMD_CUT, 32'hFFFF_FFFE);
        send_item(CMD_CUT, 32'h8000_0000);
        send_item(CMD_QUERY, 1);
        send_item(CMD_QUERY, 2);
        send_item(CMD_QUERY, 32'h8000_0001);
        send_item(CMD_QUERY, 32'hFFFF_FFFE);
    endtask

    task automatic test_duplicate_cuts();
        send_item(CMD_CUT, 32'h8000_0000);
        send_item(CMD_CUT, 1);
    endtask

    // The shortest segment leaves only position 1 valid. A later length of
    // 1000 leaves stored cuts beyond the end, so the piece is clamped.
    task automatic test_short_segment();
        wait_drained();
        write_total_length(32'd2);
        send_item(CMD_CUT, 1);
        send_item(CMD_QUERY, 1);
        send_item(CMD_CUT, 2);
        send_item(CMD_QUERY, '0);
        wait_drained();
        write_total_length(32'd1000);
        send_item(CMD_QUERY, 500);
        send_item(CMD_QUERY, 1000);
        send_item(CMD_CUT, 999);
        send_item(CMD_QUERY, 998);
    endtask

    // Random items over several segment lengths, with a drain before each
    // length change. One segment runs with no idling on either side.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] seg_choices [5];
        int               seg;
        int               n;
        logic             item_cmd;
        seg_choices[0] = $urandom_range(32'h0001_0000, 32'hFFFF_FFF0);
        seg_choices[1] = 32'd1000;
        seg_choices[2] = 32'd60;
        seg_choices[3] = 32'h4000_0001;
        seg_choices[4] = 32'hFFFF_FFFF;
        for (seg = 0; seg < 5; seg++)
        begin
            wait_drained();
            write_total_length(seg_choices[seg]);
            gaps_on = (seg != 2);
            for (n = 0; n < RANDOM_PER_SEG; n++)
            begin
                item_cmd = 1'($urandom_range(0, 1));
                send_item(item_cmd, pick_position(item_cmd));
            end
        end
        gaps_on = 1'b1;
    endtask

    // Fills the store with ascending cuts near the top of the range, which
    // keeps every insertion short, then checks cuts and queries when full.
    task automatic test_full_store();
        logic [IN_POS_W-1:0] p;
        int                  n;
        wait_drained();
        gaps_on = 1'b0;
        write_total_length(32'hFFFF_FFFF);
        p = 32'hFFFF_F000;
        while (known_cuts.size() < STORE_DEPTH)
        begin
            if (!is_known_cut(p))
                send_item(CMD_CUT, p);
            p++;
        end
        while (is_known_cut(p))
            p++;
        send_item(CMD_CUT, p);
        send_item(CMD_CUT, known_cuts[0]);
        send_item(CMD_CUT, '0);
        send_item(CMD_CUT, '1);
        for (n = 0; n < 20; n++)
            send_item(CMD_QUERY, (n % 2) ? $urandom
                                         : known_cuts[$urandom_range(0, STORE_DEPTH - 1)]);
    endtask

    // The receiver stalls in random bursts while idling is enabled.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Each output transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        piece_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pieces.size() == 0)
                note_mismatch("result with none expected, piece_length", '0, piece_length);
            else
            begin
                exp_r = expected_pieces.pop_front();
                if (piece_length !== exp_r.len)
                    note_mismatch("piece_length", exp_r.len, piece_length);
                if (status !== exp_r.sts)
                    note_mismatch("status", 32'(exp_r.sts), 32'(status));
            end
        end
    end

    // The run ends early if no transfer of any kind happens for too long.
    // The slowest legal item is an insertion at the bottom of a store with one
    // free slot, which moves every stored cut; it still ends far below the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_CUT;
        position       = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        gaps_on        = 1'b1;
        mismatch_count = 0;
        quiet_cycles   = 0;
        seg_length     = 32'hFFFF_FFFF;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_range_limits();
        test_cut_and_query();
        test_duplicate_cuts();
        test_short_segment();
        test_random_traffic();
        test_full_store();

        // Let the last results transfer, then give the block a little slack
        // in case anything extra comes out.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_pieces.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
